/* rtl/npcm_pkg.sv */
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants of the nearest palette color mapper.
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int PAL_CW        = $clog2(PALETTE_DEPTH + 1);
  localparam int COLOR_W       = 8;
  localparam int ENTRY_W       = 3 * COLOR_W;
  localparam int DIST_W        = 10;
  localparam int PIXEL_W       = 32;
  localparam int COUNT_W       = 9;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_MODE    = 3'd0,
    CFG_PALETTE_COUNT = 3'd1,
    CFG_RED_POS       = 3'd2,
    CFG_GREEN_POS     = 3'd3,
    CFG_BLUE_POS      = 3'd4,
    CFG_ALPHA_POS     = 3'd5,
    CFG_ALPHA_EN      = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_MAP  = 1'b1
  } kind_e;

  typedef struct packed {
    logic               kind;
    logic [7:0]         entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic               no_match;
  } out_t;

  // map request from the front end to the search engine
  typedef struct packed {
    logic               packed_mode;
    logic [PIXEL_W-1:0] pack_word;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [PAL_CW-1:0]  count;
  } srch_req_t;

endpackage

/* rtl/npcm_ram.sv */
// ----------------------------------------------------------------------------
// npcm_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module npcm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/npcm_store.sv */
// ----------------------------------------------------------------------------
// npcm_store
// Palette store: RAM plus per-entry valid bits; unwritten entries read zero.
// ----------------------------------------------------------------------------
module npcm_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [npcm_pkg::PAL_AW-1:0]   wr_addr_i,
  input  logic [npcm_pkg::ENTRY_W-1:0]  wr_data_i,
  input  logic                          rd_en_i,
  input  logic [npcm_pkg::PAL_AW-1:0]   rd_addr_i,
  output logic [npcm_pkg::ENTRY_W-1:0]  rd_data_o
);
  import npcm_pkg::*;

  logic [PALETTE_DEPTH-1:0] valid_q;
  logic                     rd_vld_q;
  logic [ENTRY_W-1:0]       ram_rdata;

  npcm_ram #(
    .DEPTH (PALETTE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? ram_rdata : '0;

endmodule

/* rtl/npcm_search.sv */
// ----------------------------------------------------------------------------
// npcm_search
// Search sequencer: one palette read per cycle, L1 distance, running minimum.
// ----------------------------------------------------------------------------
module npcm_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  npcm_pkg::srch_req_t           req_i,
  output logic                          busy_o,
  output logic                          rd_en_o,
  output logic [npcm_pkg::PAL_AW-1:0]   rd_addr_o,
  input  logic [npcm_pkg::ENTRY_W-1:0]  rd_data_i,
  output logic                          res_valid_o,
  output npcm_pkg::out_t                res_o,
  input  logic                          res_take_i
);
  import npcm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  function automatic logic [COLOR_W-1:0] gap(logic [COLOR_W-1:0] x, logic [COLOR_W-1:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

  state_e             state_q;
  logic               pack_q;
  logic [PIXEL_W-1:0] word_q;
  logic [COLOR_W-1:0] r_q, g_q, b_q;
  logic [PAL_CW-1:0]  n_q;
  logic [PAL_CW-1:0]  issue_q;
  logic               pend_q;
  logic [PAL_AW-1:0]  pidx_q;
  logic               found_q;
  logic [PAL_AW-1:0]  best_idx_q;
  logic [DIST_W-1:0]  best_dist_q;

  logic               rd_en;
  logic [DIST_W-1:0]  cur_dist;
  logic               better;

  assign rd_en = (state_q == S_RUN) && (issue_q < n_q);

  assign cur_dist = DIST_W'(gap(rd_data_i[3*COLOR_W-1:2*COLOR_W], r_q))
                  + DIST_W'(gap(rd_data_i[2*COLOR_W-1:COLOR_W], g_q))
                  + DIST_W'(gap(rd_data_i[COLOR_W-1:0], b_q));

  assign better = !found_q || (cur_dist < best_dist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      issue_q <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            pack_q  <= req_i.packed_mode;
            word_q  <= req_i.pack_word;
            r_q     <= req_i.red;
            g_q     <= req_i.green;
            b_q     <= req_i.blue;
            n_q     <= req_i.count;
            issue_q <= '0;
            pend_q  <= 1'b0;
            found_q <= 1'b0;
            state_q <= req_i.packed_mode ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          pend_q <= rd_en;
          pidx_q <= issue_q[PAL_AW-1:0];
          if (rd_en) begin
            issue_q <= issue_q + PAL_CW'(1);
          end
          if (pend_q && better) begin
            found_q     <= 1'b1;
            best_idx_q  <= pidx_q;
            best_dist_q <= cur_dist;
          end
          if (!rd_en && !pend_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rd_en_o     = rd_en;
  assign rd_addr_o   = issue_q[PAL_AW-1:0];
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    if (pack_q) begin
      res_o.pixel_value = word_q;
    end else if (found_q) begin
      res_o.pixel_value = PIXEL_W'(best_idx_q);
    end else begin
      res_o.pixel_value = '1;
    end
    res_o.no_match = !pack_q && !found_q;
  end

endmodule

/* rtl/nearest_palette_color_map.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_map
// Maps colors to the nearest palette entry (L1 distance) or to a packed word.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i/in_stall_o    in_data_i  (npcm_pkg::in_t)
//   out      output     out_valid_o/out_stall_i  out_data_o (npcm_pkg::out_t)
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// Load transfer: palette written on acceptance. Packed map: done state, then
// output register. Palette map: n = min(palette_count, depth) entries, one
// entry per cycle through the single palette read port.
// Reset: palette reads as zero through per-entry valid bits, no clearing pass.
// One item in the search engine at a time; a finished result in the output
// register does not block the next transfer.
// ----------------------------------------------------------------------------
module nearest_palette_color_map (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  npcm_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output npcm_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [npcm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [npcm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import npcm_pkg::*;

  function automatic logic [PIXEL_W-1:0] place_byte(logic [COLOR_W-1:0] v, logic [1:0] pos);
    return PIXEL_W'(v) << {pos, 3'b000};
  endfunction

  logic               mode_q;
  logic [COUNT_W-1:0] count_q;
  logic [1:0]         rpos_q, gpos_q, bpos_q, apos_q;
  logic               aen_q;

  logic               in_acc;
  logic               start;
  logic               wr_en;
  srch_req_t          req;
  logic               busy;
  logic               rd_en;
  logic [PAL_AW-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               res_valid;
  out_t               res;
  logic               res_take;
  logic               out_valid_q;
  out_t               out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      count_q <= COUNT_W'(256);
      rpos_q  <= 2'd2;
      gpos_q  <= 2'd1;
      bpos_q  <= 2'd0;
      apos_q  <= 2'd3;
      aen_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PIXEL_MODE:    mode_q  <= cfg_data_i[0];
        CFG_PALETTE_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_RED_POS:       rpos_q  <= cfg_data_i[1:0];
        CFG_GREEN_POS:     gpos_q  <= cfg_data_i[1:0];
        CFG_BLUE_POS:      bpos_q  <= cfg_data_i[1:0];
        CFG_ALPHA_POS:     apos_q  <= cfg_data_i[1:0];
        CFG_ALPHA_EN:      aen_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && (in_data_i.kind == KIND_MAP);
  assign wr_en      = in_acc && (in_data_i.kind == KIND_LOAD)
                   && (32'(in_data_i.entry_index) < PALETTE_DEPTH);

  always_comb begin
    req.packed_mode = mode_q;
    req.pack_word   = place_byte(in_data_i.red, rpos_q)
                    | place_byte(in_data_i.green, gpos_q)
                    | place_byte(in_data_i.blue, bpos_q)
                    | (aen_q ? place_byte(in_data_i.alpha, apos_q) : '0);
    req.red         = in_data_i.red;
    req.green       = in_data_i.green;
    req.blue        = in_data_i.blue;
    req.count       = (32'(count_q) > PALETTE_DEPTH) ? PAL_CW'(PALETTE_DEPTH)
                                                     : PAL_CW'(count_q);
  end

  npcm_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (PAL_AW'(in_data_i.entry_index)),
    .wr_data_i ({in_data_i.red, in_data_i.green, in_data_i.blue}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  npcm_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_nomatch_ones : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_match |-> out_data_o.pixel_value == '1)
    else $error("no-match result without all-ones value");

  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !busy)
    else $error("palette write during search");

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("palette read and write in the same cycle");
`endif

endmodule
